// ===== hw/rtl/integer_to_ascii_digits_assert.svh =====
// Assertion macros shared by the converter modules.
// Each macro expects clk and rst_n in scope.
`ifndef INTEGER_TO_ASCII_DIGITS_ASSERT_SVH
`define INTEGER_TO_ASCII_DIGITS_ASSERT_SVH

`define IAD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("integer_to_ascii_digits: assertion failed");

`define IAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("integer_to_ascii_digits: assertion failed");

`endif

// ===== hw/rtl/iad_pkg.sv =====
package iad_pkg;

    localparam int PAD_LIMIT  = 60;
    localparam int NUM_DIGITS = 20;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;

    localparam logic [1:0] CMD_UDEC  = 2'd0;
    localparam logic [1:0] CMD_SDEC  = 2'd1;
    localparam logic [1:0] CMD_HEX   = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam logic [1:0] SEL_SIGN  = 2'd0;
    localparam logic [1:0] SEL_PAD   = 2'd1;
    localparam logic [1:0] SEL_DIGIT = 2'd2;
    localparam logic [1:0] SEL_TERM  = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ALPHA = 8'h57;

    typedef struct packed {
        logic       load;
        logic       conv_step;
        logic       norm_step;
        logic       plan;
        logic       emit;
        logic [1:0] sel;
    } iad_cmd_t;

    typedef struct packed {
        logic hex;
        logic conv_last;
        logic norm_done;
        logic neg;
        logic pad_zero;
        logic kept_zero;
    } iad_stat_t;

endpackage

// ===== hw/rtl/iad_datapath.sv =====
`include "integer_to_ascii_digits_assert.svh"

module iad_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  iad_pkg::iad_cmd_t ctl,
    output iad_pkg::iad_stat_t stat,
    input  logic [1:0]        cmd,
    input  logic [63:0]       value,
    input  logic              is_wide,
    input  logic [5:0]        min_width,
    input  logic [6:0]        room,
    output logic [7:0]        char_out,
    output logic              last,
    output logic              strobe
);

    logic [iad_pkg::BCD_W-1:0] bcd_reg, bcd_next, bcd_adj;
    logic [63:0] bin_reg, bin_next;
    logic [5:0]  bit_cnt_reg, bit_cnt_next;
    logic [4:0]  nat_reg, nat_next;
    logic [4:0]  kept_reg, kept_next;
    logic [5:0]  pad_reg, pad_next;
    logic [5:0]  min_reg, min_next;
    logic [6:0]  room_reg, room_next;
    logic        hex_reg, hex_next;
    logic        neg_reg, neg_next;
    logic [7:0]  char_reg, char_next;
    logic        last_reg, last_next;
    logic        strobe_reg, strobe_next;

    logic [63:0] narrow_ext;
    logic [63:0] signed_val;
    logic [63:0] mag;
    logic        in_neg;
    logic        in_hex;
    logic [6:0]  cap;
    logic [4:0]  kept_calc;
    logic [3:0]  top_digit;

    always_comb
    begin
        narrow_ext = {{32{value[31]}}, value[31:0]};
        signed_val = is_wide ? value : narrow_ext;
        in_hex     = cmd inside {iad_pkg::CMD_HEX, iad_pkg::CMD_SPARE};
        in_neg     = (cmd == iad_pkg::CMD_SDEC) && signed_val[63];
        if (cmd == iad_pkg::CMD_SDEC)
        begin
            mag = in_neg ? (64'd0 - signed_val) : signed_val;
        end
        else
        begin
            mag = is_wide ? value : {32'd0, value[31:0]};
        end
    end

    always_comb
    begin
        for (int i = 0; i < iad_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    assign top_digit = bcd_reg[iad_pkg::BCD_W-1 -: 4];

    always_comb
    begin
        cap = (neg_reg && room_reg != 7'd0) ? (room_reg - 7'd1) : room_reg;
        if (room_reg != 7'd0 && {2'b00, nat_reg} > cap)
            kept_calc = cap[4:0];
        else
            kept_calc = nat_reg;
    end

    always_comb
    begin
        bcd_next     = bcd_reg;
        bin_next     = bin_reg;
        bit_cnt_next = bit_cnt_reg;
        nat_next     = nat_reg;
        kept_next    = kept_reg;
        pad_next     = pad_reg;
        min_next     = min_reg;
        room_next    = room_reg;
        hex_next     = hex_reg;
        neg_next     = neg_reg;
        char_next    = char_reg;
        last_next    = 1'b0;
        strobe_next  = 1'b0;

        if (ctl.load)
        begin
            hex_next     = in_hex;
            neg_next     = in_neg;
            room_next    = room;
            min_next     = (min_width > 6'(iad_pkg::PAD_LIMIT)) ?
                           6'(iad_pkg::PAD_LIMIT) : min_width;
            bin_next     = mag;
            bit_cnt_next = 6'd0;
            nat_next     = 5'(iad_pkg::NUM_DIGITS);
            bcd_next     = in_hex ? {16'd0, mag} : '0;
        end

        if (ctl.conv_step)
        begin
            bcd_next     = {bcd_adj[iad_pkg::BCD_W-2:0], bin_reg[63]};
            bin_next     = {bin_reg[62:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 6'd1;
        end

        if (ctl.norm_step)
        begin
            bcd_next = {bcd_reg[iad_pkg::BCD_W-5:0], 4'd0};
            nat_next = nat_reg - 5'd1;
        end

        if (ctl.plan)
        begin
            kept_next = kept_calc;
            pad_next  = (min_reg > {1'b0, kept_calc}) ? (min_reg - {1'b0, kept_calc}) : 6'd0;
        end

        if (ctl.emit)
        begin
            strobe_next = 1'b1;
            case (ctl.sel)
                iad_pkg::SEL_SIGN:
                begin
                    char_next = iad_pkg::CH_MINUS;
                end
                iad_pkg::SEL_PAD:
                begin
                    char_next = iad_pkg::CH_ZERO;
                    pad_next  = pad_reg - 6'd1;
                end
                iad_pkg::SEL_DIGIT:
                begin
                    if (top_digit < 4'ha)
                        char_next = iad_pkg::CH_ZERO + {4'd0, top_digit};
                    else
                        char_next = iad_pkg::CH_ALPHA + {4'd0, top_digit};
                    bcd_next  = {bcd_reg[iad_pkg::BCD_W-5:0], 4'd0};
                    kept_next = kept_reg - 5'd1;
                end
                default:
                begin
                    char_next = iad_pkg::CH_NUL;
                    last_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_reg   <= iad_pkg::CH_NUL;
            last_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            char_reg   <= char_next;
            last_reg   <= last_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg     <= bcd_next;
        bin_reg     <= bin_next;
        bit_cnt_reg <= bit_cnt_next;
        nat_reg     <= nat_next;
        kept_reg    <= kept_next;
        pad_reg     <= pad_next;
        min_reg     <= min_next;
        room_reg    <= room_next;
        hex_reg     <= hex_next;
        neg_reg     <= neg_next;
    end

    assign stat.hex       = hex_reg;
    assign stat.conv_last = (bit_cnt_reg == 6'd63);
    assign stat.norm_done = (top_digit != 4'd0) || (nat_reg == 5'd1);
    assign stat.neg       = neg_reg;
    assign stat.pad_zero  = (pad_reg == 6'd0);
    assign stat.kept_zero = (kept_reg == 5'd0);

    assign char_out = char_reg;
    assign last     = last_reg;
    assign strobe   = strobe_reg;

    `IAD_ASSERT_SAME(a_last_is_nul, last_reg, strobe_reg && char_reg == iad_pkg::CH_NUL)
    `IAD_ASSERT_NEXT(a_plan_fits, ctl.plan, kept_reg <= nat_reg && pad_reg <= min_reg)
    `IAD_ASSERT_SAME(a_norm_safe, ctl.norm_step, nat_reg > 5'd1 && top_digit == 4'd0)

endmodule

// ===== hw/rtl/iad_ctrl.sv =====
`include "integer_to_ascii_digits_assert.svh"

module iad_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  iad_pkg::iad_stat_t stat,
    output iad_pkg::iad_cmd_t  ctl
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_NORM  = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_DIGIT = 3'd5;
    localparam logic [2:0] ST_TERM  = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (stat.hex)
                begin
                    state_next = ST_NORM;
                end
                else
                begin
                    ctl.conv_step = 1'b1;
                    if (stat.conv_last)
                        state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (stat.norm_done)
                begin
                    ctl.plan   = 1'b1;
                    state_next = ST_SIGN;
                end
                else
                begin
                    ctl.norm_step = 1'b1;
                end
            end
            ST_SIGN:
            begin
                if (stat.neg)
                begin
                    ctl.emit = 1'b1;
                    ctl.sel  = iad_pkg::SEL_SIGN;
                end
                state_next = ST_PAD;
            end
            ST_PAD:
            begin
                if (stat.pad_zero)
                begin
                    state_next = ST_DIGIT;
                end
                else
                begin
                    ctl.emit = 1'b1;
                    ctl.sel  = iad_pkg::SEL_PAD;
                end
            end
            ST_DIGIT:
            begin
                if (stat.kept_zero)
                begin
                    state_next = ST_TERM;
                end
                else
                begin
                    ctl.emit = 1'b1;
                    ctl.sel  = iad_pkg::SEL_DIGIT;
                end
            end
            ST_TERM:
            begin
                ctl.emit   = 1'b1;
                ctl.sel    = iad_pkg::SEL_TERM;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

    `IAD_ASSERT_NEXT(a_term_to_idle, ctl.emit && ctl.sel == iad_pkg::SEL_TERM, !busy)
    `IAD_ASSERT_SAME(a_load_when_idle, ctl.load, !busy && start)
    `IAD_ASSERT_SAME(a_no_conv_hex, ctl.conv_step, !stat.hex && state_reg == ST_CONV)

endmodule

// ===== hw/rtl/integer_to_ascii_digits.sv =====
// Channel   Handshake            Payload
// request   start, busy          cmd, value, is_wide, min_width, room
// result    strobe               char_out, last
//
// A request is taken when start is high and busy is low.
// Decimal requests shift the value bit by bit into a BCD register; hex values load into it directly.
// Leading zero digits then drop one per cycle (up to 19), followed by a planning step.
// Busy then covers the sign slot (a minus only for a negative value), each pad zero and
// digit, and the NUL that ends the string.
// Reset is asynchronous and active low; each result shows for one cycle and cannot stall.
module integer_to_ascii_digits (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [63:0] value,
    input  logic        is_wide,
    input  logic [5:0]  min_width,
    input  logic [6:0]  room,
    output logic [7:0]  char_out,
    output logic        last,
    output logic        strobe
);

    iad_pkg::iad_cmd_t  ctl;
    iad_pkg::iad_stat_t stat;

    iad_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctl   (ctl)
    );

    iad_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .stat       (stat),
        .cmd        (cmd),
        .value      (value),
        .is_wide    (is_wide),
        .min_width  (min_width),
        .room       (room),
        .char_out   (char_out),
        .last       (last),
        .strobe     (strobe)
    );

endmodule
